FILE: hw/rtl/tts_pkg.sv
`timescale 1ns / 1ps
package tts_pkg;
	localparam int CFG_W     = 4;
	localparam int REG_IDX_W = 2;
	localparam int ADDR_IN_W = 17;
	localparam int TEXEL_W   = 32;
	localparam int COORD_W   = 23;
	localparam int DERIV_W   = 20;
	localparam int CHAN_W    = 16;
	localparam int COMP_W    = 8;
	localparam int FRAC_W    = 16;
	localparam int WGT_W     = 17;
	localparam int CORNERS   = 4;
	localparam int LEVELS    = 2;
	localparam int CHANNELS  = 4;

	localparam logic [CFG_W-1:0] WIDTH_LOG2_RST  = 4'd8;
	localparam logic [CFG_W-1:0] HEIGHT_LOG2_RST = 4'd8;
	localparam logic [CFG_W-1:0] LEVEL_COUNT_RST = 4'd9;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIDTH_LOG2  = 2'd0,
		REG_HEIGHT_LOG2 = 2'd1,
		REG_LEVEL_COUNT = 2'd2
	} reg_idx_t;

	// clamped configuration; top is the highest usable level
	typedef struct packed {
		logic [CFG_W-1:0] wl;
		logic [CFG_W-1:0] hl;
		logic [CFG_W-1:0] top;
	} cfg_t;

	typedef struct packed {
		logic                      sample;
		logic [ADDR_IN_W-1:0]      waddr;
		logic [TEXEL_W-1:0]        wdata;
		logic signed [COORD_W-1:0] u;
		logic signed [COORD_W-1:0] v;
	} smp_t;
endpackage

FILE: hw/rtl/tts_if.sv
`timescale 1ns / 1ps
interface tts_cfg_if;
	import tts_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface tts_smp_if;
	import tts_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [ADDR_IN_W-1:0]      texel_address;
	logic [TEXEL_W-1:0]        texel_value;
	logic signed [COORD_W-1:0] coord_u;
	logic signed [COORD_W-1:0] coord_v;
	logic [DERIV_W-1:0]        deriv_x;
	logic [DERIV_W-1:0]        deriv_y;
	modport source(output valid, command, texel_address, texel_value, coord_u, coord_v,
		deriv_x, deriv_y, input ready);
	modport sink(input valid, command, texel_address, texel_value, coord_u, coord_v,
		deriv_x, deriv_y, output ready);
endinterface

interface tts_res_if;
	import tts_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] alpha;
	modport source(output valid, red, green, blue, alpha, input ready);
	modport sink(input valid, red, green, blue, alpha, output ready);
endinterface

FILE: hw/rtl/trilinear_texture_sampler.sv
`timescale 1ns / 1ps
// channel | role   | word
// cfg     | sink   | index (register), data
// smp     | sink   | command, texel_address, texel_value, coord_u, coord_v, deriv_x, deriv_y
// res     | source | red, green, blue, alpha (8.8)
//
// One word enters every cycle while the output is not stalled.
// Stages: derivative scale and max, leading one, level and address, texel read,
// bilinear sums, level blend into the output register.
// The store is four copies, one per bilinear corner, each read for both levels.
// A stalled output holds the whole pipeline; smp.ready falls with it, nothing is lost.
// Reset clears valids and the configuration registers; the store has no reset and needs no clearing.
module trilinear_texture_sampler #(
	parameter int TEXEL_DEPTH   = 131072,
	parameter int MAX_SIZE_LOG2 = 8
) (
	input logic         clk,
	input logic         arst_n,
	tts_cfg_if.sink     cfg,
	tts_smp_if.sink     smp,
	tts_res_if.source   res
);
	import tts_pkg::*;

	localparam int MW  = DERIV_W + MAX_SIZE_LOG2;
	localparam int IPW = $clog2(MW - FRAC_W);
	localparam int AW  = 2 * MAX_SIZE_LOG2 + 1;
	localparam logic [CFG_W-1:0] MAXL = CFG_W'(MAX_SIZE_LOG2);

	logic [CFG_W-1:0] wl_q, hl_q, lc_q;
	logic [CFG_W-1:0] mn, cnt_top;
	cfg_t             cfg_c;
	logic             en;
	smp_t             in_item;
	logic             vld_s2, vld_s3, vld_s6;
	smp_t             item_s2, item_s3;
	logic [MW-1:0]    m_s2;
	logic [IPW-1:0]   ipart_s2;
	logic [COMP_W-1:0] frac_s3;
	logic [COMP_W-1:0] wu_s3 [LEVELS];
	logic [COMP_W-1:0] wv_s3 [LEVELS];
	logic [AW-1:0]    addr_s3 [LEVELS][CORNERS];
	logic [TEXEL_W-1:0] texel_s4 [LEVELS][CORNERS];
	logic             oob_s4 [LEVELS][CORNERS];
	logic [CHAN_W-1:0] rgba_s6 [CHANNELS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WIDTH_LOG2_RST;
			hl_q <= HEIGHT_LOG2_RST;
			lc_q <= LEVEL_COUNT_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_WIDTH_LOG2:  wl_q <= cfg.data;
				REG_HEIGHT_LOG2: hl_q <= cfg.data;
				REG_LEVEL_COUNT: lc_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_c.wl  = (wl_q > MAXL) ? MAXL : wl_q;
		cfg_c.hl  = (hl_q > MAXL) ? MAXL : hl_q;
		mn        = (cfg_c.wl < cfg_c.hl) ? cfg_c.wl : cfg_c.hl;
		cnt_top   = (lc_q == '0) ? '0 : lc_q - 1'b1;
		cfg_c.top = (cnt_top > mn) ? mn : cnt_top;
	end

	assign en        = !vld_s6 || res.ready;
	assign smp.ready = en;

	always_comb begin
		in_item.sample = (smp.command == CMD_SAMPLE);
		in_item.waddr  = smp.texel_address;
		in_item.wdata  = smp.texel_value;
		in_item.u      = smp.coord_u;
		in_item.v      = smp.coord_v;
	end

	tts_lod #(
		.MW(MW),
		.IPW(IPW)
	) u_lod (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(smp.valid),
		.in_item(in_item),
		.deriv_x(smp.deriv_x),
		.deriv_y(smp.deriv_y),
		.cfg(cfg_c),
		.vld_s2(vld_s2),
		.item_s2(item_s2),
		.m_s2(m_s2),
		.ipart_s2(ipart_s2)
	);

	tts_addr #(
		.MAX_SIZE_LOG2(MAX_SIZE_LOG2),
		.MW(MW),
		.IPW(IPW),
		.AW(AW)
	) u_addr (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_s2(vld_s2),
		.item_s2(item_s2),
		.m_s2(m_s2),
		.ipart_s2(ipart_s2),
		.cfg(cfg_c),
		.vld_s3(vld_s3),
		.item_s3(item_s3),
		.frac_s3(frac_s3),
		.wu_s3(wu_s3),
		.wv_s3(wv_s3),
		.addr_s3(addr_s3)
	);

	tts_texmem #(
		.TEXEL_DEPTH(TEXEL_DEPTH),
		.AW(AW)
	) u_texmem (
		.clk(clk),
		.en(en),
		.vld_s3(vld_s3),
		.item_s3(item_s3),
		.addr_s3(addr_s3),
		.texel_s4(texel_s4),
		.oob_s4(oob_s4)
	);

	tts_filter u_filter (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vld_s3(vld_s3),
		.sample_s3(item_s3.sample),
		.frac_s3(frac_s3),
		.wu_s3(wu_s3),
		.wv_s3(wv_s3),
		.texel_s4(texel_s4),
		.oob_s4(oob_s4),
		.vld_s6(vld_s6),
		.rgba_s6(rgba_s6)
	);

	assign res.valid = vld_s6;
	assign res.red   = rgba_s6[0];
	assign res.green = rgba_s6[1];
	assign res.blue  = rgba_s6[2];
	assign res.alpha = rgba_s6[3];
endmodule

FILE: hw/rtl/tts_lod.sv
`timescale 1ns / 1ps
module tts_lod #(
	parameter int MW            = 28,
	parameter int IPW           = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  tts_pkg::smp_t                  in_item,
	input  logic [tts_pkg::DERIV_W-1:0]    deriv_x,
	input  logic [tts_pkg::DERIV_W-1:0]    deriv_y,
	input  tts_pkg::cfg_t                  cfg,
	output logic                           vld_s2,
	output tts_pkg::smp_t                  item_s2,
	output logic [MW-1:0]                  m_s2,
	output logic [IPW-1:0]                 ipart_s2
);
	import tts_pkg::*;

	logic [MW-1:0]  dx, dy, m, m_s1;
	logic           vld_s1;
	smp_t           item_s1;
	logic [IPW-1:0] ipart;

	assign dx = MW'(deriv_x) << cfg.wl;
	assign dy = MW'(deriv_y) << cfg.hl;

	always_comb begin
		m = MW'(1) << FRAC_W;
		if (dx > m) begin
			m = dx;
		end
		if (dy > m) begin
			m = dy;
		end
	end

	// leading one; m never drops below one unit
	always_comb begin
		ipart = '0;
		for (int i = FRAC_W + 1; i < MW; i++) begin
			if (m_s1[i]) begin
				ipart = IPW'(i - FRAC_W);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1     <= m;
			item_s1  <= in_item;
			m_s2     <= m_s1;
			item_s2  <= item_s1;
			ipart_s2 <= ipart;
		end
	end

`ifndef SYNTHESIS
	a_lead_one: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (m_s2 >> (ipart_s2 + FRAC_W)) == MW'(1))
		else $error("lod integer part does not match leading one");
`endif
endmodule

FILE: hw/rtl/tts_addr.sv
`timescale 1ns / 1ps
module tts_addr #(
	parameter int MAX_SIZE_LOG2 = 8,
	parameter int MW            = 28,
	parameter int IPW           = 4,
	parameter int AW            = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_s2,
	input  tts_pkg::smp_t               item_s2,
	input  logic [MW-1:0]               m_s2,
	input  logic [IPW-1:0]              ipart_s2,
	input  tts_pkg::cfg_t               cfg,
	output logic                        vld_s3,
	output tts_pkg::smp_t               item_s3,
	output logic [tts_pkg::COMP_W-1:0]  frac_s3,
	output logic [tts_pkg::COMP_W-1:0]  wu_s3 [tts_pkg::LEVELS],
	output logic [tts_pkg::COMP_W-1:0]  wv_s3 [tts_pkg::LEVELS],
	output logic [AW-1:0]               addr_s3 [tts_pkg::LEVELS][tts_pkg::CORNERS]
);
	import tts_pkg::*;

	localparam int SXW = COORD_W + MAX_SIZE_LOG2;
	localparam int RW  = 2 * MAX_SIZE_LOG2;
	localparam logic [MAX_SIZE_LOG2-1:0] ONES = '1;

	logic [CFG_W-1:0]         lvl [LEVELS];
	logic [CFG_W-1:0]         lvl_s3 [LEVELS];
	logic [CFG_W-1:0]         lw [LEVELS];
	logic [CFG_W-1:0]         lh [LEVELS];
	logic [SXW-1:0]           xs [LEVELS];
	logic [SXW-1:0]           ys [LEVELS];
	logic [MAX_SIZE_LOG2-1:0] wmsk [LEVELS];
	logic [MAX_SIZE_LOG2-1:0] hmsk [LEVELS];
	logic [MAX_SIZE_LOG2-1:0] x0 [LEVELS];
	logic [MAX_SIZE_LOG2-1:0] x1 [LEVELS];
	logic [MAX_SIZE_LOG2-1:0] y0 [LEVELS];
	logic [MAX_SIZE_LOG2-1:0] y1 [LEVELS];
	logic [COMP_W-1:0]        wu [LEVELS];
	logic [COMP_W-1:0]        wv [LEVELS];
	logic [AW-1:0]            base [LEVELS];
	logic [AW-1:0]            addr [LEVELS][CORNERS];
	logic [IPW:0]             ip1;
	logic [COMP_W-1:0]        frac;

	always_comb begin
		int s;
		int d;
		ip1 = {1'b0, ipart_s2} + 1'b1;
		lvl[0] = (ipart_s2 > cfg.top) ? cfg.top : CFG_W'(ipart_s2);
		lvl[1] = (ip1 > cfg.top) ? cfg.top : CFG_W'(ip1);
		frac = COMP_W'(m_s2 >> (ipart_s2 + COMP_W));
		s = int'(cfg.wl) + int'(cfg.hl);
		for (int l = 0; l < LEVELS; l++) begin
			lw[l] = cfg.wl - lvl[l];
			lh[l] = cfg.hl - lvl[l];
			xs[l] = {{MAX_SIZE_LOG2{item_s2.u[COORD_W-1]}}, item_s2.u} << lw[l];
			ys[l] = {{MAX_SIZE_LOG2{item_s2.v[COORD_W-1]}}, item_s2.v} << lh[l];
			wmsk[l] = ~(ONES << lw[l]);
			hmsk[l] = ~(ONES << lh[l]);
			x0[l] = xs[l][FRAC_W +: MAX_SIZE_LOG2] & wmsk[l];
			y0[l] = ys[l][FRAC_W +: MAX_SIZE_LOG2] & hmsk[l];
			x1[l] = (x0[l] + 1'b1) & wmsk[l];
			y1[l] = (y0[l] + 1'b1) & hmsk[l];
			wu[l] = xs[l][FRAC_W-1 -: COMP_W];
			wv[l] = ys[l][FRAC_W-1 -: COMP_W];
			// levels before this one are 2^s, 2^(s-2), ...: one bit each
			base[l] = '0;
			for (int j = 0; j < AW; j++) begin
				d = s - j;
				if (d >= 0 && (d & 1) == 0 && d < 2 * int'(lvl[l])) begin
					base[l][j] = 1'b1;
				end
			end
			addr[l][0] = base[l] + AW'((RW'(y0[l]) << lw[l]) | RW'(x0[l]));
			addr[l][1] = base[l] + AW'((RW'(y0[l]) << lw[l]) | RW'(x1[l]));
			addr[l][2] = base[l] + AW'((RW'(y1[l]) << lw[l]) | RW'(x0[l]));
			addr[l][3] = base[l] + AW'((RW'(y1[l]) << lw[l]) | RW'(x1[l]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= item_s2;
			frac_s3 <= frac;
			wu_s3   <= wu;
			wv_s3   <= wv;
			addr_s3 <= addr;
			lvl_s3  <= lvl;
		end
	end

`ifndef SYNTHESIS
	a_lvl_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> lvl_s3[0] <= lvl_s3[1] && lvl_s3[1] <= cfg.top)
		else $error("mip levels out of order or past the top level");
	a_lvl_step: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> ({1'b0, lvl_s3[0]} + 1'b1) >= {1'b0, lvl_s3[1]})
		else $error("mip levels more than one apart");
`endif
endmodule

FILE: hw/rtl/tts_texmem.sv
`timescale 1ns / 1ps
module tts_texmem #(
	parameter int TEXEL_DEPTH = 131072,
	parameter int AW          = 17
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic                         vld_s3,
	input  tts_pkg::smp_t                item_s3,
	input  logic [AW-1:0]                addr_s3 [tts_pkg::LEVELS][tts_pkg::CORNERS],
	output logic [tts_pkg::TEXEL_W-1:0]  texel_s4 [tts_pkg::LEVELS][tts_pkg::CORNERS],
	output logic                         oob_s4 [tts_pkg::LEVELS][tts_pkg::CORNERS]
);
	import tts_pkg::*;

	localparam int IW  = $clog2(TEXEL_DEPTH);
	localparam int EW  = (AW > IW ? AW : IW) + 1;
	localparam int WEW = (ADDR_IN_W > IW ? ADDR_IN_W : IW) + 1;

	logic [WEW-1:0] wext;
	logic           wr_en;

	assign wext  = WEW'(item_s3.waddr);
	assign wr_en = en && vld_s3 && !item_s3.sample && (wext < WEW'(TEXEL_DEPTH));

	// one copy per bilinear corner, each with a read port per level
	for (genvar c = 0; c < CORNERS; c++) begin : g_copy
		logic [TEXEL_W-1:0] mem [TEXEL_DEPTH];
		logic [EW-1:0]      ra_ext [LEVELS];

		always_comb begin
			for (int l = 0; l < LEVELS; l++) begin
				ra_ext[l] = EW'(addr_s3[l][c]);
			end
		end

		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[wext[IW-1:0]] <= item_s3.wdata;
			end
			if (en) begin
				texel_s4[0][c] <= mem[ra_ext[0][IW-1:0]];
				texel_s4[1][c] <= mem[ra_ext[1][IW-1:0]];
				oob_s4[0][c]   <= ra_ext[0] >= EW'(TEXEL_DEPTH);
				oob_s4[1][c]   <= ra_ext[1] >= EW'(TEXEL_DEPTH);
			end
		end
	end
endmodule

FILE: hw/rtl/tts_filter.sv
`timescale 1ns / 1ps
module tts_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_s3,
	input  logic                         sample_s3,
	input  logic [tts_pkg::COMP_W-1:0]   frac_s3,
	input  logic [tts_pkg::COMP_W-1:0]   wu_s3 [tts_pkg::LEVELS],
	input  logic [tts_pkg::COMP_W-1:0]   wv_s3 [tts_pkg::LEVELS],
	input  logic [tts_pkg::TEXEL_W-1:0]  texel_s4 [tts_pkg::LEVELS][tts_pkg::CORNERS],
	input  logic                         oob_s4 [tts_pkg::LEVELS][tts_pkg::CORNERS],
	output logic                         vld_s6,
	output logic [tts_pkg::CHAN_W-1:0]   rgba_s6 [tts_pkg::CHANNELS]
);
	import tts_pkg::*;

	localparam int SUM_W = COMP_W + WGT_W;
	localparam int BL_W  = CHAN_W + COMP_W + 1;

	logic [COMP_W:0]   iu [LEVELS];
	logic [COMP_W:0]   iv [LEVELS];
	logic [WGT_W-1:0]  w [LEVELS][CORNERS];
	logic [WGT_W-1:0]  w_s4 [LEVELS][CORNERS];
	logic [COMP_W-1:0] frac_s4, frac_s5;
	logic              vld_s4, vld_s5;
	logic [TEXEL_W-1:0] t [LEVELS][CORNERS];
	logic [SUM_W-1:0]  acc [LEVELS][CHANNELS];
	logic [CHAN_W-1:0] lvl_s5 [LEVELS][CHANNELS];
	logic [COMP_W:0]   ifrac;
	logic [BL_W-1:0]   mix [CHANNELS];

	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			iu[l] = 9'd256 - {1'b0, wu_s3[l]};
			iv[l] = 9'd256 - {1'b0, wv_s3[l]};
			w[l][0] = WGT_W'(iu[l]) * WGT_W'(iv[l]);
			w[l][1] = WGT_W'(wu_s3[l]) * WGT_W'(iv[l]);
			w[l][2] = WGT_W'(iu[l]) * WGT_W'(wv_s3[l]);
			w[l][3] = WGT_W'(wu_s3[l]) * WGT_W'(wv_s3[l]);
		end
	end

	// texels past the end of the store read as zero
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			for (int c = 0; c < CORNERS; c++) begin
				t[l][c] = oob_s4[l][c] ? '0 : texel_s4[l][c];
			end
			for (int ch = 0; ch < CHANNELS; ch++) begin
				acc[l][ch] = '0;
				for (int c = 0; c < CORNERS; c++) begin
					acc[l][ch] = acc[l][ch]
						+ SUM_W'(t[l][c][COMP_W*ch +: COMP_W]) * SUM_W'(w_s4[l][c]);
				end
			end
		end
	end

	always_comb begin
		ifrac = 9'd256 - {1'b0, frac_s5};
		for (int ch = 0; ch < CHANNELS; ch++) begin
			mix[ch] = BL_W'(lvl_s5[0][ch]) * BL_W'(ifrac)
				+ BL_W'(lvl_s5[1][ch]) * BL_W'(frac_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3 && sample_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s4    <= w;
			frac_s4 <= frac_s3;
			frac_s5 <= frac_s4;
			for (int l = 0; l < LEVELS; l++) begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					lvl_s5[l][ch] <= acc[l][ch][COMP_W +: CHAN_W];
				end
			end
			for (int ch = 0; ch < CHANNELS; ch++) begin
				rgba_s6[ch] <= mix[ch][COMP_W +: CHAN_W];
			end
		end
	end

`ifndef SYNTHESIS
	a_wgt_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (19'(w_s4[0][0]) + 19'(w_s4[0][1]) + 19'(w_s4[0][2])
			+ 19'(w_s4[0][3])) == 19'd65536
			&& (19'(w_s4[1][0]) + 19'(w_s4[1][1]) + 19'(w_s4[1][2])
			+ 19'(w_s4[1][3])) == 19'd65536)
		else $error("bilinear weights do not sum to one");
`endif
endmodule
